// ===== rtl/stq_pkg.sv =====
// Shared types and constants of the sorted timer queue.
package stq_pkg;

   localparam int SLOT_W      = 4;
   localparam int TICK_W      = 32;
   localparam int ACTION_W    = 2;
   localparam int KIND_W      = 2;
   localparam int MAX_FIRE    = 16;
   localparam int FIRE_CNT_W  = $clog2(MAX_FIRE + 1);
   localparam int FIRE_IDX_W  = $clog2(MAX_FIRE);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ARM_ONCE     = 2'd0,
      ACT_ARM_PERIODIC = 2'd1,
      ACT_STOP         = 2'd2,
      ACT_TICK         = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STATUS   = 2'd0,
      KIND_FIRED    = 2'd1,
      KIND_NONE_DUE = 2'd2
   } kind_type;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_PARAM_ERR = 1'b1;

   typedef enum logic [1:0] {
      CMD_REJECT,
      CMD_ARM,
      CMD_STOP,
      CMD_TICK
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [SLOT_W-1:0] slot;
      logic              periodic;
      logic [TICK_W-1:0] period;
      logic [TICK_W-1:0] expiry;
      logic [TICK_W-1:0] now;
   } cmd_type;

endpackage

// ===== rtl/stq_if.sv =====
// Request and response channel interfaces of the sorted timer queue.
interface stq_req_if;
   import stq_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SLOT_W-1:0]   timer_slot;
   logic [TICK_W-1:0]   tick_amount;
   logic [TICK_W-1:0]   current_tick;

   modport source(output valid, action, timer_slot, tick_amount, current_tick, input ready);
   modport sink(input valid, action, timer_slot, tick_amount, current_tick, output ready);
endinterface

interface stq_rsp_if;
   import stq_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic              status_code;
   logic [SLOT_W-1:0] fired_slot;
   logic              last_result;

   modport source(output valid, result_kind, status_code, fired_slot, last_result, input ready);
   modport sink(input valid, result_kind, status_code, fired_slot, last_result, output ready);
endinterface

// ===== rtl/stq_front.sv =====
// Request decoder and command queue of the sorted timer queue.
module stq_front #(
   parameter int NUM_TIMERS = 16
) (
   input  logic             clock,
   input  logic             reset,
   stq_req_if.sink          req_if,
   output stq_pkg::cmd_type cmd_out,
   output logic             cmd_valid,
   input  logic             cmd_take
);
   import stq_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;
   localparam int CNT_W = 2;

   cmd_type          queue_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   cmd_type          cmd_new;
   logic             push;
   logic             pop;
   logic             arm_ok;

   assign req_if.ready = (count_ff != CNT_W'(DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign pop          = cmd_take && cmd_valid;
   assign cmd_valid    = (count_ff != '0);
   assign cmd_out      = queue_ff[rd_ptr_ff];

   // A zero delay or an out-of-range slot turns an arm into a rejected request.
   assign arm_ok = (req_if.tick_amount != '0) && (32'(req_if.timer_slot) < NUM_TIMERS);

   always_comb begin
      cmd_new.slot     = req_if.timer_slot;
      cmd_new.periodic = (req_if.action == ACT_ARM_PERIODIC);
      cmd_new.period   = req_if.tick_amount;
      cmd_new.expiry   = req_if.current_tick + req_if.tick_amount;
      cmd_new.now      = req_if.current_tick;
      unique case (req_if.action) inside
         ACT_ARM_ONCE, ACT_ARM_PERIODIC: cmd_new.op = arm_ok ? CMD_ARM : CMD_REJECT;
         ACT_STOP:                       cmd_new.op = CMD_STOP;
         default:                        cmd_new.op = CMD_TICK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/stq_back.sv =====
// Sorted timer list engine: removal, insertion, expiry and result register.
module stq_back #(
   parameter int NUM_TIMERS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  stq_pkg::cmd_type cmd_in,
   input  logic             cmd_valid,
   output logic             cmd_take,
   stq_rsp_if.source        rsp_if
);
   import stq_pkg::*;

   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int IDX_W = $clog2(NUM_TIMERS);

   typedef struct packed {
      logic [SLOT_W-1:0] id;
      logic              periodic;
      logic [TICK_W-1:0] period;
      logic [TICK_W-1:0] key;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SHIFT,
      ST_INSERT,
      ST_REPLY,
      ST_POP,
      ST_FIRE
   } state_type;

   state_type             state_ff;
   cmd_type               cmd_ff;
   entry_type             list_ff [NUM_TIMERS];
   entry_type             list_in [NUM_TIMERS];
   entry_type             due_ff [MAX_FIRE];
   logic [CNT_W-1:0]      count_ff;
   logic [FIRE_CNT_W-1:0] due_cnt_ff;
   logic [FIRE_IDX_W-1:0] fire_idx_ff;
   logic [IDX_W-1:0]      hole_ff;
   kind_type              reply_kind_ff;
   logic                  reply_err_ff;

   logic                  rsp_valid_ff;
   kind_type              kind_ff;
   logic                  status_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  last_ff;

   logic                  out_free;
   logic                  rsp_load;
   logic                  found;
   logic [IDX_W-1:0]      found_idx;
   logic                  head_due;
   logic                  last_fire;
   logic                  ins_en;
   logic                  shift_en;
   logic [IDX_W-1:0]      hole_sel;
   entry_type             ins_entry;
   entry_type             cmd_entry;
   entry_type             due_cur;
   logic [NUM_TIMERS-1:0] gt;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load  = out_free && (state_ff == ST_REPLY || state_ff == ST_FIRE);
   assign due_cur   = due_ff[fire_idx_ff];
   assign last_fire = ({1'b0, fire_idx_ff} + 1'b1) == due_cnt_ff;
   assign head_due  = (count_ff != '0) && (due_cnt_ff != FIRE_CNT_W'(MAX_FIRE))
                      && (list_ff[0].key <= cmd_ff.now);
   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid;

   assign cmd_entry.id       = cmd_ff.slot;
   assign cmd_entry.periodic = cmd_ff.periodic;
   assign cmd_entry.period   = cmd_ff.period;
   assign cmd_entry.key      = cmd_ff.expiry;

   assign ins_en = (count_ff < CNT_W'(NUM_TIMERS))
                   && ((state_ff == ST_INSERT)
                       || (state_ff == ST_FIRE && out_free && due_cur.periodic));
   assign ins_entry = (state_ff == ST_FIRE) ? due_cur : cmd_entry;
   assign shift_en  = (state_ff == ST_SHIFT) || (state_ff == ST_POP && head_due);
   assign hole_sel  = (state_ff == ST_SHIFT) ? hole_ff : '0;

   // Locate the slot being re-armed or stopped; a slot is in the list at most once.
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (CNT_W'(i) < count_ff && list_ff[i].id == cmd_ff.slot) begin
            found     = 1'b1;
            found_idx = IDX_W'(i);
         end
      end
   end

   // Insertion goes behind every entry whose key is not later, so ties keep arm order.
   // Since the list is sorted, gt is monotonic and each entry only looks at its neighbor.
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (list_ff[i].key > ins_entry.key);
      end
      list_in = list_ff;
      if (ins_en) begin
         if (gt[0] || count_ff == '0) begin
            list_in[0] = ins_entry;
         end
         for (int i = 1; i < NUM_TIMERS; i++) begin
            if (gt[i-1]) begin
               list_in[i] = list_ff[i-1];
            end else if (gt[i] || CNT_W'(i) == count_ff) begin
               list_in[i] = ins_entry;
            end
         end
      end else if (shift_en) begin
         for (int i = 0; i < NUM_TIMERS - 1; i++) begin
            if (IDX_W'(i) >= hole_sel) begin
               list_in[i] = list_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_in;
      if (state_ff == ST_POP && head_due) begin
         due_ff[due_cnt_ff[FIRE_IDX_W-1:0]] <= '{
            id:       list_ff[0].id,
            periodic: list_ff[0].periodic,
            period:   list_ff[0].period,
            key:      cmd_ff.now + list_ff[0].period
         };
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         due_cnt_ff    <= '0;
         fire_idx_ff   <= '0;
         hole_ff       <= '0;
         reply_kind_ff <= KIND_STATUS;
         reply_err_ff  <= STATUS_OK;
         rsp_valid_ff  <= 1'b0;
         kind_ff       <= KIND_STATUS;
         status_ff     <= STATUS_OK;
         slot_ff       <= '0;
         last_ff       <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ins_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (shift_en) begin
            count_ff <= count_ff - 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff        <= cmd_in;
                  reply_kind_ff <= KIND_STATUS;
                  reply_err_ff  <= (cmd_in.op == CMD_REJECT) ? STATUS_PARAM_ERR : STATUS_OK;
                  due_cnt_ff    <= '0;
                  unique case (cmd_in.op)
                     CMD_REJECT: state_ff <= ST_REPLY;
                     CMD_TICK:   state_ff <= ST_POP;
                     default:    state_ff <= ST_FIND;
                  endcase
               end
            end
            ST_FIND: begin
               hole_ff <= found_idx;
               if (found) begin
                  state_ff <= ST_SHIFT;
               end else begin
                  state_ff <= (cmd_ff.op == CMD_ARM) ? ST_INSERT : ST_REPLY;
               end
            end
            ST_SHIFT: begin
               state_ff <= (cmd_ff.op == CMD_ARM) ? ST_INSERT : ST_REPLY;
            end
            ST_INSERT: begin
               state_ff <= ST_REPLY;
            end
            ST_REPLY: begin
               if (out_free) begin
                  kind_ff      <= reply_kind_ff;
                  status_ff    <= reply_err_ff;
                  slot_ff      <= '0;
                  last_ff      <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_POP: begin
               if (head_due) begin
                  due_cnt_ff <= due_cnt_ff + 1'b1;
               end else if (due_cnt_ff == '0) begin
                  reply_kind_ff <= KIND_NONE_DUE;
                  state_ff      <= ST_REPLY;
               end else begin
                  fire_idx_ff <= '0;
                  state_ff    <= ST_FIRE;
               end
            end
            ST_FIRE: begin
               if (out_free) begin
                  kind_ff      <= KIND_FIRED;
                  status_ff    <= STATUS_OK;
                  slot_ff      <= due_cur.id;
                  last_ff      <= last_fire;
                  fire_idx_ff  <= fire_idx_ff + 1'b1;
                  if (last_fire) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_kind = kind_ff;
   assign rsp_if.status_code = status_ff;
   assign rsp_if.fired_slot  = slot_ff;
   assign rsp_if.last_result = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_TIMERS))
      else $error("timer list count exceeds capacity");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2) |-> list_ff[0].key <= list_ff[1].key)
      else $error("timer list head out of order");

   a_due_bound: assert property (@(posedge clock) disable iff (reset)
      due_cnt_ff <= FIRE_CNT_W'(MAX_FIRE))
      else $error("too many timers collected in one tick");

   a_fire_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIRE && out_free && last_fire) |=> state_ff == ST_IDLE)
      else $error("tick did not finish after its final fired result");

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: request decoder, command queue and list engine.
//
//   channel | direction | payload
//   req_if  | in        | action, timer_slot, tick_amount, current_tick
//   rsp_if  | out       | result_kind, status_code, fired_slot, last_result
//
// An arm steps through find, remove (if listed), insert and reply; a stop through
// find, remove and reply. A tick collects due timers from the list head, one per
// cycle, then returns one fired result per cycle while the response is not stalled,
// or a single none-due result when none is due.
// Synchronous reset empties the list at once; there is no clearing pass.
// Two decoded requests can wait in the command queue while a result is stalled.
module sorted_timer_queue #(
   parameter int NUM_TIMERS = 16
) (
   input logic       clock,
   input logic       reset,
   stq_req_if.sink   req_if,
   stq_rsp_if.source rsp_if
);
   import stq_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;

   stq_front #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_out   (cmd),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take)
   );

   stq_back #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (cmd),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .rsp_if    (rsp_if)
   );

endmodule
